### rtl/button_debounce_mode_select_assert.svh
// ---------------------------------------------------------------------------
// Button debounce mode select: assertion macros
// Clocked, reset-qualified assertion helpers used by bdms_core.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_MODE_SELECT_ASSERT_SVH
`define BUTTON_DEBOUNCE_MODE_SELECT_ASSERT_SVH

// Same-cycle implication.
`define BDMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bdms_pkg.sv
// ---------------------------------------------------------------------------
// bdms_pkg
// Types and constants for the button debounce and mode select block.
// ---------------------------------------------------------------------------
package bdms_pkg;

  localparam int unsigned BtnW     = 4;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned ModeW    = 8;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned NumModesW = 9;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  // button bit positions
  localparam int unsigned BitUp    = 0;
  localparam int unsigned BitDown  = 1;
  localparam int unsigned BitLeft  = 2;
  localparam int unsigned BitRight = 3;

  // reported button codes
  localparam logic [CodeW-1:0] CodeNone  = 3'd0;
  localparam logic [CodeW-1:0] CodeUp    = 3'd1;
  localparam logic [CodeW-1:0] CodeDown  = 3'd2;
  localparam logic [CodeW-1:0] CodeLeft  = 3'd3;
  localparam logic [CodeW-1:0] CodeRight = 3'd4;

  // register indexes (paddr[2])
  localparam logic RegThreshold = 1'b0;
  localparam logic RegNumModes  = 1'b1;

  localparam logic [ThrW-1:0]      ThresholdRst = 8'd3;
  localparam logic [NumModesW-1:0] NumModesRst  = 9'd8;

  typedef struct packed {
    logic [ThrW-1:0]      threshold;
    logic [NumModesW-1:0] num_modes;
  } cfg_t;

  typedef struct packed {
    logic             changed;
    logic [CodeW-1:0] pressed_button;
    logic [ModeW-1:0] mode_index;
  } result_t;

endpackage

### rtl/button_debounce_mode_select.sv
// ---------------------------------------------------------------------------
// button_debounce_mode_select
// Four-button debouncer with a wrapping up/down mode index.
// ---------------------------------------------------------------------------
// One button sample is taken per transaction, every cycle if the neighbors
// allow: the debounce state and the output register both update at
// acceptance. in_ready_o stays high while that register is empty or being
// taken, so throughput is one item per clock. The two registers (threshold
// at 0x0, mode count at 0x4) are written through a zero-wait-state APB port
// and should only be changed while idle.
module button_debounce_mode_select import bdms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [BtnW-1:0]  buttons_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             changed_o,
  output logic [CodeW-1:0] pressed_button_o,
  output logic [ModeW-1:0] mode_index_o
);

  cfg_t    cfg_q, cfg_d;
  result_t res, res_q;
  logic    out_valid_q, out_valid_d;
  logic    in_fire;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        RegThreshold: cfg_d.threshold = pwdata[ThrW-1:0];
        RegNumModes:  cfg_d.num_modes = pwdata[NumModesW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegThreshold: prdata = DataW'(cfg_q.threshold);
      RegNumModes:  prdata = DataW'(cfg_q.num_modes);
      default:      prdata = '0;
    endcase
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  bdms_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_fire),
    .buttons_i (buttons_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThresholdRst;
      cfg_q.num_modes <= NumModesRst;
      out_valid_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign changed_o        = res_q.changed;
  assign pressed_button_o = res_q.pressed_button;
  assign mode_index_o     = res_q.mode_index;

endmodule

### rtl/bdms_core.sv
// ---------------------------------------------------------------------------
// bdms_core
// Debounce state, priority decode and mode counter; one sample per transaction.
// ---------------------------------------------------------------------------
`include "button_debounce_mode_select_assert.svh"

module bdms_core import bdms_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [BtnW-1:0] buttons_i,
  input  cfg_t            cfg_i,
  output result_t         res_o
);

  logic [BtnW-1:0]  prev_q, prev_d;
  logic [BtnW-1:0]  orig_q, orig_d;
  logic             armed_q, armed_d;
  logic [ThrW-1:0]  cnt_q, cnt_d;
  logic [CodeW-1:0] last_q, last_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic             changed;
  logic [ThrW-1:0]  cnt_inc;
  logic [ModeW-1:0] top;

  always_comb begin
    if (cfg_i.num_modes == '0) begin
      top = '0;
    end else if (cfg_i.num_modes[NumModesW-1]) begin
      top = '1;
    end else begin
      top = ModeW'(cfg_i.num_modes - NumModesW'(1));
    end
  end

  assign cnt_inc = cnt_q + ThrW'(1);

  always_comb begin
    prev_d  = prev_q;
    orig_d  = orig_q;
    armed_d = armed_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    mode_d  = mode_q;
    changed = 1'b0;
    if (accept_i) begin
      prev_d = buttons_i;
      if (buttons_i != '0 && buttons_i != prev_q) begin
        if (!armed_q) begin
          armed_d = 1'b1;
          orig_d  = prev_q;
        end else if (buttons_i == orig_q) begin
          armed_d = 1'b0;
        end
        cnt_d = '0;
      end else if (armed_q) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= cfg_i.threshold) begin
          changed = 1'b1;
          armed_d = 1'b0;
          cnt_d   = '0;
        end
      end
      if (changed) begin
        if (buttons_i[BitUp]) begin
          last_d = CodeUp;
          mode_d = (mode_q < top) ? mode_q + ModeW'(1) : '0;
        end else if (buttons_i[BitDown]) begin
          last_d = CodeDown;
          mode_d = (mode_q != '0) ? mode_q - ModeW'(1) : top;
        end else if (buttons_i[BitLeft]) begin
          last_d = CodeLeft;
        end else if (buttons_i[BitRight]) begin
          last_d = CodeRight;
        end else begin
          last_d = CodeNone;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      orig_q  <= '0;
      armed_q <= 1'b0;
      cnt_q   <= '0;
      last_q  <= CodeNone;
      mode_q  <= '0;
    end else begin
      prev_q  <= prev_d;
      orig_q  <= orig_d;
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      mode_q  <= mode_d;
    end
  end

  assign res_o.changed        = changed;
  assign res_o.pressed_button = last_d;
  assign res_o.mode_index     = mode_d;

  `BDMS_ASSERT_IMP(a_chg_needs_armed, accept_i && changed, armed_q, "change while disarmed")
  `BDMS_ASSERT_NXT(a_chg_disarms, accept_i && changed, !armed_q && cnt_q == '0, "not disarmed")
  `BDMS_ASSERT_IMP(a_idle_cnt_zero, !armed_q, cnt_q == '0, "count nonzero while disarmed")
  `BDMS_ASSERT_NXT(a_mode_hold, !(accept_i && changed), $stable(mode_q) && $stable(last_q),
                   "result state moved without a change")

endmodule
